FILE: hdl/brf_pkg.sv
package brf_pkg;

	// ring geometry
	localparam int BRF_DEPTH = 1024;
	localparam int PTR_W = $clog2(BRF_DEPTH);
	localparam int LEN_W = 11;
	localparam int MAX_RUN = 64;
	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam int PREFIX_BYTES = 4;
	localparam int PFX_W = $clog2(PREFIX_BYTES);
	localparam int SIZE_W = 8 * PREFIX_BYTES;

	// operation codes
	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_FORCE = 3'd1;
	localparam logic [2:0] OP_READ = 3'd2;
	localparam logic [2:0] OP_MWRITE = 3'd3;
	localparam logic [2:0] OP_MREAD = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_DROP = 2'd3;

	typedef struct packed {
		logic [2:0]       operation;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] run_length;
		logic             first_of_run;
	} req_t;

	typedef struct packed {
		logic [7:0]       read_byte;
		logic             byte_valid;
		logic [1:0]       status;
		logic [LEN_W-1:0] free_bytes;
		logic             last;
	} res_t;

	// classified request kinds
	typedef enum logic [2:0] {
		K_WRITE  = 3'd0,
		K_MWRITE = 3'd1,
		K_FORCE  = 3'd2,
		K_READ   = 3'd3,
		K_MREAD  = 3'd4,
		K_NONE   = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] run_length;
		logic             first_of_run;
	} cmd_t;

endpackage

FILE: hdl/byte_ring_fifo_with_message_framing_top.sv
// Byte ring FIFO with message framing.
// Requests enter on req_valid/req_stall with a req_t payload; results leave
// on res_valid/res_stall with a res_t payload. A request is taken on a clock
// edge with valid high and stall low. Requests first go into a two-entry
// queue, so the front keeps taking them while the sequencer works.
// Writes, force writes and unused codes give one result from the response
// state; a message write first writes the four-byte length prefix and the
// first byte. Read runs give one result per byte; each byte is fetched
// through the registered read port of the ring store. Message reads fetch
// each prefix byte through that port and pop discarded tail bytes unread.
// cfg_we loads the ring size and empties the ring; write it only while idle.
// Reset empties the ring and sets the size to the full store depth; no
// clearing pass runs. While res_stall holds a result in the register, the
// sequencer waits at its next result; the queue fills and raises req_stall.
module byte_ring_fifo_with_message_framing_top import brf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	brf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	brf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// a ring byte always comes with an ok status
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.byte_valid |-> res.status == ST_OK)
		else $error("ring byte with non-ok status");

	// no byte, no data
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.byte_valid |-> res.read_byte == 8'h00)
		else $error("read_byte set without byte_valid");

	// free space never beyond the store depth
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.free_bytes <= LEN_W'(BRF_DEPTH))
		else $error("free_bytes out of range");

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

endmodule

FILE: hdl/brf_front.sv
module brf_front import brf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic cmd_valid,
	input  logic cmd_pop,
	output cmd_t cmd
);

	cmd_t       q_ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;

	// classify the incoming request
	always_comb begin
		cls.data_byte = req.data_byte;
		cls.run_length = req.run_length;
		cls.first_of_run = req.first_of_run;
		case (req.operation)
			OP_WRITE: cls.kind = K_WRITE;
			OP_MWRITE: cls.kind = K_MWRITE;
			OP_FORCE: cls.kind = K_FORCE;
			OP_READ: cls.kind = K_READ;
			OP_MREAD: cls.kind = K_MREAD;
			default: cls.kind = K_NONE;
		endcase
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_ent_q[rd_ptr_q];

	// two-entry queue towards the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !cmd_pop) cnt_q <= cnt_q + 2'd1;
			else if (cmd_pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_ent_q[wr_ptr_q] <= cls;
	end

endmodule

FILE: hdl/brf_back.sv
module brf_back import brf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  cmd_t             cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MPFX = 11'b00000000010,
		S_MPAY = 11'b00000000100,
		S_RESP = 11'b00000001000,
		S_RISS = 11'b00000010000,
		S_RDAT = 11'b00000100000,
		S_MISS = 11'b00001000000,
		S_MDAT = 11'b00010000000,
		S_PISS = 11'b00100000000,
		S_PDAT = 11'b01000000000,
		S_DISC = 11'b10000000000
	} state_t;

	function automatic logic [PTR_W:0] bump_f(input logic [PTR_W-1:0] p,
			input logic [LEN_W-1:0] cap);
		logic [LEN_W-1:0] n;
		n = LEN_W'(p) + LEN_W'(1);
		if (n >= cap) return {1'b1, {PTR_W{1'b0}}};
		return {1'b0, n[PTR_W-1:0]};
	endfunction

	logic [7:0]        ring_mem [BRF_DEPTH];
	logic [7:0]        rd_data_q;
	state_t            state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [LEN_W-1:0]  cap_q;
	logic [PTR_W-1:0]  wp_q, rp_q;
	logic              wm_q, rm_q;
	logic              run_acc_q, run_acc_d;
	logic [LEN_W-1:0]  run_rem_q, run_rem_d;
	logic [1:0]        st_q, st_d;
	logic [RUN_W-1:0]  want_q, want_d, n_q, n_d, take_q, take_d;
	logic [PFX_W-1:0]  idx_q, idx_d;
	logic [SIZE_W-1:0] size_q, size_d, size_n, rest_q, rest_d;
	res_t              out_q;
	logic              out_vld_q;

	logic [LEN_W-1:0] fill_c, free_c;
	logic             empty_c, full_c, can_emit;
	logic             push_c, pop_c, rd_en_c;
	logic [7:0]       wdata_c;
	logic             emit_c, e_valid, e_last;
	logic [7:0]       e_byte;
	logic [1:0]       e_st;
	logic [LEN_W:0]   need_c;
	logic [PTR_W:0]   wp_nx, rp_nx;
	logic [LEN_W-1:0] cfg_cap;
	logic             last_c;

	// occupancy from pointers and mirror bits
	always_comb begin
		if (wm_q == rm_q) fill_c = LEN_W'(wp_q) - LEN_W'(rp_q);
		else fill_c = cap_q - LEN_W'(rp_q) + LEN_W'(wp_q);
		free_c = cap_q - fill_c;
		empty_c = (fill_c == '0);
		full_c = (fill_c >= cap_q);
	end

	assign can_emit = !out_vld_q || !res_stall;
	assign wp_nx = bump_f(wp_q, cap_q);
	assign rp_nx = bump_f(rp_q, cap_q);

	// sequencer
	always_comb begin
		state_d = state_q;
		cmd_d = cmd_q;
		run_acc_d = run_acc_q;
		run_rem_d = run_rem_q;
		st_d = st_q;
		want_d = want_q;
		n_d = n_q;
		take_d = take_q;
		idx_d = idx_q;
		size_d = size_q;
		rest_d = rest_q;
		size_n = size_q;
		cmd_pop = 1'b0;
		push_c = 1'b0;
		pop_c = 1'b0;
		rd_en_c = 1'b0;
		wdata_c = cmd_q.data_byte;
		emit_c = 1'b0;
		e_valid = 1'b0;
		e_last = 1'b1;
		e_byte = '0;
		e_st = ST_OK;
		need_c = '0;
		last_c = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d = cmd;
					wdata_c = cmd.data_byte;
					state_d = S_RESP;
					st_d = ST_OK;
					case (cmd.kind)
						K_WRITE, K_MWRITE: begin
							if (cmd.first_of_run) begin
								need_c = (cmd.kind == K_MWRITE)
									? {1'b0, cmd.run_length} + (LEN_W + 1)'(PREFIX_BYTES)
									: {1'b0, cmd.run_length};
								if ((cmd.kind == K_WRITE && cmd.run_length == '0) ||
										{1'b0, free_c} < need_c) begin
									run_acc_d = 1'b0;
									run_rem_d = '0;
									st_d = ST_REJECT;
								end else if (cmd.kind == K_MWRITE) begin
									idx_d = '0;
									state_d = S_MPFX;
								end else begin
									push_c = 1'b1;
									run_rem_d = cmd.run_length - LEN_W'(1);
									run_acc_d = (cmd.run_length != LEN_W'(1));
								end
							end else if (!run_acc_q || run_rem_q == '0) begin
								st_d = ST_DROP;
							end else begin
								run_rem_d = run_rem_q - LEN_W'(1);
								if (run_rem_q == LEN_W'(1)) run_acc_d = 1'b0;
								if (full_c) st_d = ST_DROP;
								else push_c = 1'b1;
							end
						end
						K_FORCE: begin
							pop_c = full_c;
							push_c = 1'b1;
						end
						K_READ: begin
							want_d = (cmd.run_length > LEN_W'(MAX_RUN))
								? RUN_W'(MAX_RUN) : cmd.run_length[RUN_W-1:0];
							n_d = '0;
							if (want_d == '0) st_d = ST_OK;
							else if (empty_c) st_d = ST_EMPTY;
							else state_d = S_RISS;
						end
						K_MREAD: begin
							if (empty_c) begin
								st_d = ST_EMPTY;
							end else begin
								size_d = '0;
								idx_d = '0;
								state_d = S_MISS;
							end
						end
						default: st_d = ST_OK;
					endcase
				end
			end
			// little-endian length prefix
			S_MPFX: begin
				push_c = 1'b1;
				case (idx_q)
					2'd0: wdata_c = cmd_q.run_length[7:0];
					2'd1: wdata_c = 8'(cmd_q.run_length[LEN_W-1:8]);
					default: wdata_c = 8'h00;
				endcase
				idx_d = idx_q + PFX_W'(1);
				if (idx_q == PFX_W'(PREFIX_BYTES - 1)) state_d = S_MPAY;
			end
			S_MPAY: begin
				st_d = ST_OK;
				state_d = S_RESP;
				if (cmd_q.run_length == '0) begin
					run_acc_d = 1'b0;
					run_rem_d = '0;
				end else begin
					push_c = 1'b1;
					run_rem_d = cmd_q.run_length - LEN_W'(1);
					run_acc_d = (cmd_q.run_length != LEN_W'(1));
				end
			end
			S_RESP: begin
				if (can_emit) begin
					emit_c = 1'b1;
					e_st = st_q;
					state_d = S_IDLE;
				end
			end
			S_RISS: begin
				rd_en_c = 1'b1;
				pop_c = 1'b1;
				state_d = S_RDAT;
			end
			S_RDAT: begin
				last_c = (n_q + RUN_W'(1) == want_q) || empty_c;
				if (can_emit) begin
					emit_c = 1'b1;
					e_valid = 1'b1;
					e_byte = rd_data_q;
					e_last = last_c;
					n_d = n_q + RUN_W'(1);
					state_d = last_c ? S_IDLE : S_RISS;
				end
			end
			S_MISS: begin
				rd_en_c = 1'b1;
				pop_c = 1'b1;
				state_d = S_MDAT;
			end
			S_MDAT: begin
				size_n[{idx_q, 3'b000} +: 8] = rd_data_q;
				size_d = size_n;
				if (idx_q == PFX_W'(PREFIX_BYTES - 1) || empty_c) begin
					n_d = '0;
					take_d = (size_n > SIZE_W'(MAX_RUN))
						? RUN_W'(MAX_RUN) : size_n[RUN_W-1:0];
					if (size_n == '0) begin
						st_d = ST_OK;
						state_d = S_RESP;
					end else if (empty_c) begin
						st_d = ST_EMPTY;
						state_d = S_RESP;
					end else begin
						state_d = S_PISS;
					end
				end else begin
					idx_d = idx_q + PFX_W'(1);
					state_d = S_MISS;
				end
			end
			S_PISS: begin
				rd_en_c = 1'b1;
				pop_c = 1'b1;
				state_d = S_PDAT;
			end
			S_PDAT: begin
				last_c = (n_q + RUN_W'(1) == take_q) || empty_c;
				if (last_c) begin
					rest_d = size_q - SIZE_W'(n_q + RUN_W'(1));
					state_d = S_DISC;
				end else if (can_emit) begin
					emit_c = 1'b1;
					e_valid = 1'b1;
					e_byte = rd_data_q;
					e_last = 1'b0;
					n_d = n_q + RUN_W'(1);
					state_d = S_PISS;
				end
			end
			// drop the tail beyond the run cap, then send the held last byte
			S_DISC: begin
				if (rest_q != '0 && !empty_c) begin
					pop_c = 1'b1;
					rest_d = rest_q - SIZE_W'(1);
				end else if (can_emit) begin
					emit_c = 1'b1;
					e_valid = 1'b1;
					e_byte = rd_data_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// capacity clamp on write
	always_comb begin
		cfg_cap = cfg_data;
		if (cfg_data == '0) cfg_cap = LEN_W'(1);
		else if (cfg_data > LEN_W'(BRF_DEPTH)) cfg_cap = LEN_W'(BRF_DEPTH);
	end

	// control and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= LEN_W'(BRF_DEPTH);
			wp_q <= '0;
			rp_q <= '0;
			wm_q <= 1'b0;
			rm_q <= 1'b0;
			run_acc_q <= 1'b0;
			run_rem_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_cap;
				wp_q <= '0;
				rp_q <= '0;
				wm_q <= 1'b0;
				rm_q <= 1'b0;
				run_acc_q <= 1'b0;
				run_rem_q <= '0;
			end else begin
				run_acc_q <= run_acc_d;
				run_rem_q <= run_rem_d;
				if (push_c) begin
					wp_q <= wp_nx[PTR_W-1:0];
					wm_q <= wm_q ^ wp_nx[PTR_W];
				end
				if (pop_c) begin
					rp_q <= rp_nx[PTR_W-1:0];
					rm_q <= rm_q ^ rp_nx[PTR_W];
				end
			end
			if (emit_c) out_vld_q <= 1'b1;
			else if (!res_stall) out_vld_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		st_q <= st_d;
		want_q <= want_d;
		n_q <= n_d;
		take_q <= take_d;
		idx_q <= idx_d;
		size_q <= size_d;
		rest_q <= rest_d;
		if (emit_c) begin
			out_q.read_byte <= e_byte;
			out_q.byte_valid <= e_valid;
			out_q.status <= e_st;
			out_q.free_bytes <= free_c;
			out_q.last <= e_last;
		end
	end

	// ring store, registered read
	always_ff @(posedge clk) begin
		if (push_c) ring_mem[wp_q] <= wdata_c;
		if (rd_en_c) rd_data_q <= ring_mem[rp_q];
	end

	assign res_valid = out_vld_q;
	assign res = out_q;

endmodule
